FILE: design/bfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the bitmap frame allocator
// Map geometry, action and status codes, and the reserved-frame helper.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Geometry of the frame map.
    localparam int MAX_FRAMES  = 8192;
    localparam int PAGE_BYTES  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_BYTES  = WORD_BITS / 8;
    localparam int MAP_WORDS   = MAX_FRAMES / WORD_BITS;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WADDR_W     = $clog2(MAP_WORDS);
    localparam int FRAME_W     = $clog2(MAX_FRAMES);
    localparam int COUNT_W     = FRAME_W + 1;
    localparam int ADDR_W      = 32;
    localparam int PFRAME_W    = ADDR_W - PAGE_SHIFT;
    localparam int CFG_W       = 32;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] RESET_FRAMES = COUNT_W'(7680);
    localparam logic [ADDR_W-1:0]  RESET_BASE   = 32'h0020_0000;

    // Configuration register indexes.
    localparam logic CFG_FRAME_COUNT = 1'b0;
    localparam logic CFG_POOL_BASE   = 1'b1;

    // Request actions.
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_MARK  = 2'd2;
    localparam logic [1:0] ACT_INIT  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SAME  = 2'd3;

    // Outcome of a search over one map word.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_pos;
    } scan_result_t;

    // Frames occupied by the map itself for n managed frames, never above n.
    function automatic logic [COUNT_W-1:0] reserved_frames(input logic [COUNT_W-1:0] n);
        logic [COUNT_W:0]   words;
        logic [COUNT_W+2:0] bytes;
        logic [COUNT_W+2:0] pages;
        words = ({1'b0, n} + (COUNT_W+1)'(WORD_BITS - 1)) >> BIT_W;
        bytes = (COUNT_W+3)'(words) << $clog2(WORD_BYTES);
        pages = (bytes + (COUNT_W+3)'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
        if (pages > (COUNT_W+3)'(n))
        begin
            return n;
        end
        return pages[COUNT_W-1:0];
    endfunction

    localparam logic [COUNT_W-1:0] RESET_RESERVED = reserved_frames(RESET_FRAMES);
    localparam logic [COUNT_W-1:0] RESET_FREE     = RESET_FRAMES - RESET_RESERVED;

endpackage
`default_nettype wire

FILE: design/bfa_map_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_map_ram: used-frame map storage
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_map_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: design/bfa_word_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_word_scan: free-frame search within one map word
// Masks the bits outside the search window and finds the lowest free frame.
// ----------------------------------------------------------------------------
module bfa_word_scan (
    input  wire logic [bfa_pkg::WORD_BITS-1:0] word_data,
    input  wire logic                          first_word,
    input  wire logic [bfa_pkg::BIT_W-1:0]     lo_bit,
    input  wire logic                          last_word,
    input  wire logic [bfa_pkg::BIT_W-1:0]     hi_bit,
    output bfa_pkg::scan_result_t              result
);
    import bfa_pkg::*;

    localparam logic [BIT_W-1:0] BIT_MAX = BIT_W'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] avail;

    // Free bits at or above the hint in the first word, and below the end.
    always_comb
    begin
        avail = ~word_data;
        if (first_word)
        begin
            avail = avail & ({WORD_BITS{1'b1}} << lo_bit);
        end
        if (last_word)
        begin
            avail = avail & ({WORD_BITS{1'b1}} >> (BIT_MAX - hi_bit));
        end
    end

    // Lowest free bit wins.
    always_comb
    begin
        result.found   = |avail;
        result.bit_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                result.bit_pos = BIT_W'(b);
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: page-frame allocator over a one-bit-per-frame map
// Allocates, frees and marks frames, and re-initializes the map on request.
// ----------------------------------------------------------------------------
// Usage:
//   A request (action, address, mark_frame) is taken when in_valid is high
//   and in_stall is low. Each request returns exactly one result (frame_address,
//   status, free_count) on the out_valid / out_stall channel, in order.
//   frame_count and pool_base are written through cfg_we / cfg_index /
//   cfg_data while the block is idle; frame_count takes effect on init.
//   Allocate, free and mark pass from the idle state through decode, then scan
//   (allocate) or read-modify-write (free, mark), then the response state,
//   which loads the output register once it is free. A free or mark out of
//   range and an allocate with nothing free skip the map access and go from
//   decode straight to the response state. An allocate that has to walk the
//   map stays longer in scan for each extra 32-frame word, since the search
//   reads one map word per cycle from the RAM. Init rewrites all 256 map
//   words, one per cycle, then responds. After reset the same clearing pass
//   runs with in_stall high; configuration writes are still taken during it.
//   A finished result sits in an output register, so the next request is
//   accepted while it waits; a further result waits until that one is taken.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write port
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [bfa_pkg::CFG_W-1:0]     cfg_data,
    // Request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    action,
    input  wire logic [bfa_pkg::ADDR_W-1:0]    address,
    input  wire logic [bfa_pkg::FRAME_W-1:0]   mark_frame,
    // Result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [bfa_pkg::ADDR_W-1:0]    frame_address,
    output logic      [1:0]                    status,
    output logic      [bfa_pkg::COUNT_W-1:0]   free_count
);
    import bfa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RMW,
        S_RESP
    } state_t;

    // Control and configuration state.
    state_t               state_reg;
    logic [COUNT_W-1:0]   frame_count_reg;
    logic [ADDR_W-1:0]    pool_base_reg;
    logic [COUNT_W-1:0]   active_reg;
    logic [COUNT_W-1:0]   reserved_reg;
    logic [COUNT_W-1:0]   free_frames_reg;
    logic [COUNT_W-1:0]   hint_reg;
    logic [WADDR_W-1:0]   clr_word_reg;
    logic                 init_resp_reg;
    logic                 pass_reg;
    logic [WADDR_W-1:0]   chk_word_reg;
    logic [FRAME_W-1:0]   target_reg;

    // Latched request.
    logic [1:0]           action_reg;
    logic [ADDR_W-1:0]    address_reg;
    logic [FRAME_W-1:0]   mark_frame_reg;

    // Pending result and output register.
    logic [ADDR_W-1:0]    res_addr_reg;
    logic [1:0]           res_status_reg;
    logic                 out_valid_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic [1:0]           out_status_reg;
    logic [COUNT_W-1:0]   out_free_reg;

    // Map RAM ports.
    logic                 ram_wr_en;
    logic [WADDR_W-1:0]   ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [WADDR_W-1:0]   ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;

    // Derived values.
    logic [COUNT_W-1:0]   sat_count;
    logic [ADDR_W-1:0]    free_offset;
    logic [PFRAME_W-1:0]  free_idx;
    logic                 free_out;
    logic                 mark_out;
    logic [FRAME_W-1:0]   req_target;
    logic                 hint_past_end;
    logic [WADDR_W-1:0]   start_word;
    logic [COUNT_W-1:0]   last_frame;
    logic [WADDR_W-1:0]   last_word_idx;
    logic                 at_last_word;
    logic [WADDR_W-1:0]   next_word;
    logic [FRAME_W-1:0]   hit_frame;
    logic [WORD_BITS-1:0] hit_mask;
    logic [WORD_BITS-1:0] target_mask;
    logic                 target_used;
    logic [WORD_BITS-1:0] reserve_mask;
    logic                 out_free_slot;
    scan_result_t         scan;

    bfa_map_ram #(
        .DEPTH(MAP_WORDS),
        .WIDTH(WORD_BITS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Search window within the word that is being checked.
    bfa_word_scan u_word_scan (
        .word_data  (ram_rd_data),
        .first_word (!pass_reg && (chk_word_reg == hint_reg[FRAME_W-1:BIT_W])),
        .lo_bit     (hint_reg[BIT_W-1:0]),
        .last_word  (at_last_word),
        .hi_bit     (last_frame[BIT_W-1:0]),
        .result     (scan)
    );

    // Frame count saturates at the map size when init takes it over.
    assign sat_count = (frame_count_reg > COUNT_W'(MAX_FRAMES)) ?
                       COUNT_W'(MAX_FRAMES) : frame_count_reg;

    // Range checks of free and mark requests.
    assign free_offset = address_reg - pool_base_reg;
    assign free_idx    = free_offset[ADDR_W-1:PAGE_SHIFT];
    assign free_out    = (address_reg < pool_base_reg) ||
                         (free_idx >= PFRAME_W'(active_reg));
    assign mark_out    = ({1'b0, mark_frame_reg} >= active_reg);
    assign req_target  = (action_reg == ACT_FREE) ? free_idx[FRAME_W-1:0] : mark_frame_reg;

    // Allocation search bounds.
    assign hint_past_end = (hint_reg >= active_reg);
    assign start_word    = hint_past_end ? '0 : hint_reg[FRAME_W-1:BIT_W];
    assign last_frame    = active_reg - COUNT_W'(1);
    assign last_word_idx = last_frame[FRAME_W-1:BIT_W];
    assign at_last_word  = (chk_word_reg == last_word_idx);
    assign next_word     = (at_last_word && !pass_reg) ? '0 : chk_word_reg + WADDR_W'(1);
    assign hit_frame     = {chk_word_reg, scan.bit_pos};
    assign hit_mask      = WORD_BITS'(1) << scan.bit_pos;

    // Single-bit access of free and mark.
    assign target_mask = WORD_BITS'(1) << target_reg[BIT_W-1:0];
    assign target_used = ram_rd_data[target_reg[BIT_W-1:0]];

    // Reserved frames that fall into the word being cleared.
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            reserve_mask[b] = ({1'b0, clr_word_reg, BIT_W'(b)} < reserved_reg);
        end
    end

    assign out_free_slot = !out_valid_reg || !out_stall;

    // Map RAM access for each state.
    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = next_word;
        ram_wr_en   = 1'b0;
        ram_wr_addr = chk_word_reg;
        ram_wr_data = ram_rd_data | hit_mask;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_word_reg;
                ram_wr_data = reserve_mask;
            end
            S_DECODE:
            begin
                if (action_reg == ACT_ALLOC)
                begin
                    ram_rd_en   = (free_frames_reg != '0);
                    ram_rd_addr = start_word;
                end
                else if (action_reg == ACT_FREE)
                begin
                    ram_rd_en   = !free_out;
                    ram_rd_addr = req_target[FRAME_W-1:BIT_W];
                end
                else if (action_reg == ACT_MARK)
                begin
                    ram_rd_en   = !mark_out;
                    ram_rd_addr = req_target[FRAME_W-1:BIT_W];
                end
            end
            S_SCAN:
            begin
                ram_rd_en = 1'b1;
                ram_wr_en = scan.found;
            end
            S_RMW:
            begin
                ram_wr_addr = target_reg[FRAME_W-1:BIT_W];
                if (action_reg == ACT_FREE)
                begin
                    ram_wr_en   = target_used;
                    ram_wr_data = ram_rd_data & ~target_mask;
                end
                else
                begin
                    ram_wr_en   = !target_used;
                    ram_wr_data = ram_rd_data | target_mask;
                end
            end
            S_IDLE, S_RESP:
            begin
                ram_wr_en = 1'b0;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= RESET_FRAMES;
            pool_base_reg   <= RESET_BASE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_COUNT: frame_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_POOL_BASE:   pool_base_reg   <= cfg_data[ADDR_W-1:0];
                default:         pool_base_reg   <= pool_base_reg;
            endcase
        end
    end

    // Request latch; payload only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            action_reg     <= action;
            address_reg    <= address;
            mark_frame_reg <= mark_frame;
        end
    end

    // Sequencer with allocator state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            active_reg      <= RESET_FRAMES;
            reserved_reg    <= RESET_RESERVED;
            free_frames_reg <= RESET_FREE;
            hint_reg        <= '0;
            clr_word_reg    <= '0;
            init_resp_reg   <= 1'b0;
            pass_reg        <= 1'b0;
            chk_word_reg    <= '0;
            target_reg      <= '0;
            res_addr_reg    <= '0;
            res_status_reg  <= ST_DONE;
            out_valid_reg   <= 1'b0;
            out_addr_reg    <= '0;
            out_status_reg  <= ST_DONE;
            out_free_reg    <= '0;
        end
        else
        begin
            // The receiver takes the result; a new one loaded below replaces it.
            if (out_valid_reg && !out_stall && (state_reg != S_RESP))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                // Map rewrite, one word per cycle.
                S_CLEAR:
                begin
                    clr_word_reg <= clr_word_reg + WADDR_W'(1);
                    if (clr_word_reg == WADDR_W'(MAP_WORDS - 1))
                    begin
                        free_frames_reg <= active_reg - reserved_reg;
                        res_addr_reg    <= '0;
                        res_status_reg  <= ST_DONE;
                        state_reg       <= init_resp_reg ? S_RESP : S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DECODE;
                    end
                end

                S_DECODE:
                begin
                    res_addr_reg <= '0;
                    target_reg   <= req_target;
                    unique case (action_reg)
                        ACT_ALLOC:
                        begin
                            if (free_frames_reg == '0)
                            begin
                                res_status_reg <= ST_EMPTY;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                res_status_reg <= ST_DONE;
                                pass_reg       <= hint_past_end;
                                chk_word_reg   <= start_word;
                                state_reg      <= S_SCAN;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (free_out)
                            begin
                                res_status_reg <= ST_RANGE;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                res_status_reg <= ST_DONE;
                                state_reg      <= S_RMW;
                            end
                        end
                        ACT_MARK:
                        begin
                            if (mark_out)
                            begin
                                res_status_reg <= ST_RANGE;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                res_status_reg <= ST_DONE;
                                state_reg      <= S_RMW;
                            end
                        end
                        ACT_INIT:
                        begin
                            active_reg    <= sat_count;
                            reserved_reg  <= reserved_frames(sat_count);
                            hint_reg      <= '0;
                            clr_word_reg  <= '0;
                            init_resp_reg <= 1'b1;
                            state_reg     <= S_CLEAR;
                        end
                        default:
                        begin
                            res_status_reg <= ST_DONE;
                            state_reg      <= S_RESP;
                        end
                    endcase
                end

                // One map word checked per cycle; the next read is already issued.
                S_SCAN:
                begin
                    priority if (scan.found)
                    begin
                        res_addr_reg <= pool_base_reg + (ADDR_W'(hit_frame) << PAGE_SHIFT);
                        if (free_frames_reg != '0)
                        begin
                            free_frames_reg <= free_frames_reg - COUNT_W'(1);
                        end
                        if ({1'b0, hit_frame} == hint_reg)
                        begin
                            hint_reg <= hint_reg + COUNT_W'(1);
                        end
                        state_reg <= S_RESP;
                    end
                    else if (at_last_word && pass_reg)
                    begin
                        res_status_reg <= ST_EMPTY;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        if (at_last_word)
                        begin
                            pass_reg <= 1'b1;
                        end
                        chk_word_reg <= next_word;
                    end
                end

                // Single-bit update of free and mark.
                S_RMW:
                begin
                    if (action_reg == ACT_FREE)
                    begin
                        if (target_used)
                        begin
                            free_frames_reg <= free_frames_reg + COUNT_W'(1);
                            if ({1'b0, target_reg} < hint_reg)
                            begin
                                hint_reg <= {1'b0, target_reg};
                            end
                        end
                        else
                        begin
                            res_status_reg <= ST_SAME;
                        end
                    end
                    else
                    begin
                        if (!target_used)
                        begin
                            if (free_frames_reg != '0)
                            begin
                                free_frames_reg <= free_frames_reg - COUNT_W'(1);
                            end
                        end
                        else
                        begin
                            res_status_reg <= ST_SAME;
                        end
                    end
                    state_reg <= S_RESP;
                end

                // Hand the result to the output register once it is free.
                S_RESP:
                begin
                    if (out_free_slot)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_addr_reg   <= res_addr_reg;
                        out_status_reg <= res_status_reg;
                        out_free_reg   <= free_frames_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign frame_address = out_addr_reg;
    assign status        = out_status_reg;
    assign free_count    = out_free_reg;

endmodule
`default_nettype wire

FILE: test/tb_bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator: self-checking bench for the bitmap frame allocator
// Sends allocate, free, mark and init requests under random idling and
// back-pressure. A local copy of the frame map predicts each result, and every
// result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator;
    import bfa_pkg::*;

    localparam int RANDOM_REQUESTS = 1750;
    localparam int HOLD_CYCLES     = 400;

    typedef struct packed {
        logic [1:0]         action;
        logic [ADDR_W-1:0]  address;
        logic [FRAME_W-1:0] mark_frame;
    } frame_request_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  frame_address;
        logic [1:0]         status;
        logic [COUNT_W-1:0] free_count;
    } frame_result_t;

    // Block ports.
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_we      = 1'b0;
    logic                cfg_index   = CFG_FRAME_COUNT;
    logic [CFG_W-1:0]    cfg_data    = '0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [1:0]          action      = ACT_ALLOC;
    logic [ADDR_W-1:0]   address     = '0;
    logic [FRAME_W-1:0]  mark_frame  = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [ADDR_W-1:0]   frame_address;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  free_count;

    // Local copy of the allocator state and its registers.
    logic [COUNT_W-1:0]  cfg_frames = RESET_FRAMES;
    logic [ADDR_W-1:0]   cfg_base   = RESET_BASE;
    bit                  frame_used [MAX_FRAMES];
    int unsigned         live_frames;
    int unsigned         free_left;
    int unsigned         scan_hint;

    // Requests waiting to be sent and results waiting to arrive.
    frame_request_t      pending_requests [$];
    frame_result_t       awaited_results [$];

    bit                  req_taken      = 1'b0;
    int                  send_idle_pct  = 9;
    int                  recv_stall_pct = 49;
    bit                  hold_req       = 1'b0;
    int                  hold_left      = 0;
    int                  fail_count     = 0;

    bitmap_frame_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .address       (address),
        .mark_frame    (mark_frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_address (frame_address),
        .status        (status),
        .free_count    (free_count)
    );

    // Clear the map for the latched frame count and reserve the map's own frames.
    function automatic void rebuild_map();
        int unsigned n;
        int unsigned reserved;
        n = (cfg_frames > MAX_FRAMES) ? MAX_FRAMES : cfg_frames;
        reserved = (((n + WORD_BITS - 1) / WORD_BITS) * (WORD_BITS / 8) + PAGE_BYTES - 1)
                   / PAGE_BYTES;
        live_frames = n;
        free_left   = n;
        scan_hint   = 0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            frame_used[i] = 1'b0;
        end
        for (int unsigned i = 0; i < reserved && i < n; i++)
        begin
            frame_used[i] = 1'b1;
            free_left--;
        end
    endfunction

    // Apply one request to the local map and return the result it produces.
    function automatic frame_result_t next_frame_result(input frame_request_t req);
        frame_result_t res;
        int unsigned   idx;
        int unsigned   hit;
        bit            found;
        res.frame_address = '0;
        res.status        = ST_DONE;
        found             = 1'b0;
        hit               = 0;
        case (req.action)
            ACT_ALLOC:
            begin
                // Search from the hint to the top, then wrap below the hint.
                if (free_left != 0)
                begin
                    for (idx = scan_hint; idx < live_frames && !found; idx++)
                    begin
                        if (!frame_used[idx])
                        begin
                            found = 1'b1;
                            hit   = idx;
                        end
                    end
                    for (idx = 0; idx < scan_hint && idx < live_frames && !found; idx++)
                    begin
                        if (!frame_used[idx])
                        begin
                            found = 1'b1;
                            hit   = idx;
                        end
                    end
                end
                if (found)
                begin
                    frame_used[hit] = 1'b1;
                    if (free_left > 0)
                    begin
                        free_left--;
                    end
                    if (hit == scan_hint)
                    begin
                        scan_hint++;
                    end
                    res.frame_address = cfg_base + hit * PAGE_BYTES;
                end
                else
                begin
                    res.status = ST_EMPTY;
                end
            end
            ACT_FREE:
            begin
                // Unaligned addresses fall to their frame; a real free pulls the hint down.
                if (req.address < cfg_base)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    idx = (req.address - cfg_base) / PAGE_BYTES;
                    if (idx >= live_frames)
                    begin
                        res.status = ST_RANGE;
                    end
                    else if (frame_used[idx])
                    begin
                        frame_used[idx] = 1'b0;
                        free_left++;
                        if (idx < scan_hint)
                        begin
                            scan_hint = idx;
                        end
                    end
                    else
                    begin
                        res.status = ST_SAME;
                    end
                end
            end
            ACT_MARK:
            begin
                // Marking never touches the hint.
                if (req.mark_frame >= live_frames)
                begin
                    res.status = ST_RANGE;
                end
                else if (frame_used[req.mark_frame])
                begin
                    res.status = ST_SAME;
                end
                else
                begin
                    frame_used[req.mark_frame] = 1'b1;
                    if (free_left > 0)
                    begin
                        free_left--;
                    end
                end
            end
            ACT_INIT:
            begin
                rebuild_map();
            end
        endcase
        res.free_count = free_left[COUNT_W-1:0];
        return res;
    endfunction

    // Write one configuration register; the block is idle whenever this runs.
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FRAME_COUNT)
        begin
            cfg_frames = value[COUNT_W-1:0];
        end
        else
        begin
            cfg_base = value;
        end
    endtask

    task automatic queue_request(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                                 input logic [FRAME_W-1:0] index);
        frame_request_t req;
        req.action     = act;
        req.address    = addr;
        req.mark_frame = index;
        pending_requests.push_back(req);
    endtask

    // Wait until every request has been sent and every result has come back.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Clock.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Accepted request: predict its result.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            awaited_results.push_back(next_frame_result({action, address, mark_frame}));
            void'(pending_requests.pop_front());
            req_taken = 1'b1;
        end
    end

    // Present the next request, or hold a stalled one unchanged.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !req_taken))
        begin
            req_taken = 1'b0;
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid   <= 1'b1;
                action     <= pending_requests[0].action;
                address    <= pending_requests[0].address;
                mark_frame <= pending_requests[0].mark_frame;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side stalls, with one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : check_result
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no request outstanding: addr=%h status=%0d free=%0d",
                       frame_address, status, free_count);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (frame_address !== want.frame_address)
                begin
                    $error("frame_address: expected %h, got %h",
                           want.frame_address, frame_address);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (free_count !== want.free_count)
                begin
                    $error("free_count: expected %0d, got %0d", want.free_count, free_count);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: directed requests, then random phases under three idling regimes.
    initial
    begin : stimulus
        int                 sent;
        int                 phase_len;
        int                 pick;
        int unsigned        n;
        logic [CFG_W-1:0]   word;
        logic [ADDR_W-1:0]  addr;
        bit                 pressure_done;
        sent          = 0;
        pressure_done = 1'b0;
        rebuild_map();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration, checked without an init first.
        queue_request(ACT_ALLOC, '0, '0);
        queue_request(ACT_MARK, '0, 13'd0);
        queue_request(ACT_MARK, '0, 13'd8191);
        queue_request(ACT_MARK, '0, 13'd7679);
        queue_request(ACT_FREE, 32'h0000_0000, '0);
        queue_request(ACT_FREE, 32'hFFFF_FFFF, '0);
        queue_request(ACT_FREE, RESET_BASE + 7679 * PAGE_BYTES + PAGE_BYTES - 1, '0);
        queue_request(ACT_FREE, RESET_BASE + 7679 * PAGE_BYTES, '0);
        queue_request(ACT_FREE, RESET_BASE, '0);
        queue_request(ACT_ALLOC, '0, '0);
        queue_request(ACT_ALLOC, 32'hFFFF_FFFF, 13'h1FFF);
        wait_idle();

        // No frames managed at all.
        write_reg(CFG_FRAME_COUNT, 32'd0);
        write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
        queue_request(ACT_INIT, '0, '0);
        queue_request(ACT_ALLOC, '0, '0);
        queue_request(ACT_FREE, 32'hFFFF_FFFF, '0);
        queue_request(ACT_MARK, '0, 13'd0);
        wait_idle();

        // Two frames, the second one wrapping the address space to zero.
        write_reg(CFG_FRAME_COUNT, 32'd2);
        write_reg(CFG_POOL_BASE, 32'hFFFF_F000);
        queue_request(ACT_INIT, '0, '0);
        queue_request(ACT_ALLOC, '0, '0);
        queue_request(ACT_ALLOC, '0, '0);
        queue_request(ACT_FREE, 32'h0000_0000, '0);
        queue_request(ACT_FREE, 32'hFFFF_F800, '0);
        queue_request(ACT_ALLOC, '0, '0);
        wait_idle();

        // Oversized frame count saturates to the full map.
        write_reg(CFG_FRAME_COUNT, 32'd16383);
        write_reg(CFG_POOL_BASE, 32'h0000_0000);
        queue_request(ACT_INIT, '0, '0);
        queue_request(ACT_MARK, '0, 13'd8191);
        queue_request(ACT_ALLOC, '0, '0);
        queue_request(ACT_FREE, 32'd8191 * PAGE_BYTES, '0);

        // Random phases, each opened by a new frame count, often a new pool base, and an init.
        while (sent < RANDOM_REQUESTS)
        begin
            wait_idle();
            if (sent >= 2 * RANDOM_REQUESTS / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else if (sent >= RANDOM_REQUESTS / 3)
            begin
                send_idle_pct  = 49;
                recv_stall_pct = 9;
            end

            // Mostly small maps, so they fill up and drain often.
            pick = $urandom_range(0, 99);
            if (pick < 55)
                word = $urandom_range(1, 40);
            else if (pick < 72)
                word = $urandom_range(41, 300);
            else if (pick < 80)
                word = $urandom_range(1, MAX_FRAMES);
            else if (pick < 85)
                word = 0;
            else if (pick < 90)
                word = MAX_FRAMES;
            else if (pick < 95)
                word = $urandom_range(MAX_FRAMES + 1, 16383);
            else
                word = $urandom;
            write_reg(CFG_FRAME_COUNT, word);

            pick = $urandom_range(0, 99);
            if (pick >= 40)
            begin
                if (pick < 60)
                    word = $urandom;
                else if (pick < 70)
                    word = 32'h0000_0000;
                else if (pick < 80)
                    word = 32'hFFFF_FFFF;
                else if (pick < 90)
                    word = 32'hFFFF_F000 - ($urandom_range(0, 20) << PAGE_SHIFT);
                else
                    word = $urandom & ~(PAGE_BYTES - 1);
                write_reg(CFG_POOL_BASE, word);
            end

            n = (cfg_frames > MAX_FRAMES) ? MAX_FRAMES : cfg_frames;
            if (send_idle_pct == 0 && !pressure_done)
            begin
                hold_req      = 1'b1;
                pressure_done = 1'b1;
            end

            queue_request(ACT_INIT, $urandom, FRAME_W'($urandom));
            sent++;
            phase_len = $urandom_range(30, 110);
            for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    queue_request(ACT_ALLOC, $urandom, FRAME_W'($urandom));
                end
                else if (pick < 65)
                begin
                    // Free a frame near or inside the range, now and then unaligned.
                    addr = cfg_base + $urandom_range(0, n + 1) * PAGE_BYTES;
                    if ($urandom_range(0, 1))
                    begin
                        addr = addr + $urandom_range(0, PAGE_BYTES - 1);
                    end
                    queue_request(ACT_FREE, addr, FRAME_W'($urandom));
                end
                else if (pick < 75)
                begin
                    queue_request(ACT_FREE, $urandom, FRAME_W'($urandom));
                end
                else if (pick < 90)
                begin
                    queue_request(ACT_MARK, $urandom, FRAME_W'($urandom_range(0, n + 1)));
                end
                else if (pick < 96)
                begin
                    queue_request(ACT_MARK, $urandom, FRAME_W'($urandom));
                end
                else
                begin
                    queue_request(ACT_INIT, $urandom, FRAME_W'($urandom));
                end
                sent++;
            end
        end

        // Drain, then let any stray result show up.
        while (pending_requests.size() != 0 || awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("bitmap_frame_allocator regression: pass");
        end
        else
        begin
            $display("bitmap_frame_allocator regression: fail");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("bitmap_frame_allocator regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
design/bfa_pkg.sv
design/bfa_map_ram.sv
design/bfa_word_scan.sv
design/bitmap_frame_allocator.sv
test/tb_bitmap_frame_allocator.sv
